// ===== hw/rtl/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// bed_pkg
// Shared constants, codes and types for the button event debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bed_pkg;

	localparam int BUTTONS     = 4;
	localparam int QUEUE_DEPTH = 16;
	// event store is split into one bank per button so a tick can push to all
	localparam int BANKS       = BUTTONS;
	localparam int BANK_W      = $clog2(BANKS);
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int ROW_W       = QPTR_W - BANK_W;
	localparam int ROWS        = QUEUE_DEPTH / BANKS;
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int REQ_CNT_W   = $clog2(BUTTONS + 1);
	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DC_TICKS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DC_MASK      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = 3'd5;

	localparam logic [7:0]         RST_DEBOUNCE     = 8'd3;
	localparam logic [15:0]        RST_LONG_TICKS   = 16'd100;
	localparam logic [15:0]        RST_DC_TICKS     = 16'd30;
	localparam logic [BUTTONS-1:0] RST_ACTIVE_LOW   = 4'hF;
	localparam logic [BUTTONS-1:0] RST_DC_MASK      = 4'h0;
	localparam logic [2:0]         RST_BUTTON_COUNT = 3'd4;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_PRESSED = 4'b0010,
		PH_LONG    = 4'b0100,
		PH_WAIT    = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		EV_PRESSED  = 2'd0,
		EV_RELEASED = 2'd1,
		EV_LONG     = 2'd2,
		EV_DOUBLE   = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic [7:0]  debounce;
		logic [15:0] long_ticks;
		logic [15:0] dc_ticks;
	} lane_cfg_t;

	typedef struct packed {
		logic     req;
		ev_kind_t kind;
	} ev_req_t;

	typedef struct packed {
		logic [1:0]  button;
		ev_kind_t    kind;
		logic [31:0] stamp;
	} ev_entry_t;

	typedef struct packed {
		logic               event_valid;
		logic [1:0]         event_button;
		ev_kind_t           event_kind;
		logic [31:0]        event_stamp;
		logic [BUTTONS-1:0] held_mask;
		logic [LEVEL_W-1:0] queue_level;
		logic [2:0]         dropped_now;
	} result_t;

endpackage

// ===== hw/rtl/bed_lane.sv =====
// ----------------------------------------------------------------------------
// bed_lane
// Debounce, long press and double click machine of one button.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bed_lane
	import bed_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      pressed,
	input  lane_cfg_t cfg,
	input  logic      dc_en,
	output ev_req_t   ev,
	output logic      held_nxt
);

	phase_t      phase_q, phase_d;
	logic [7:0]  press_q, press_d;
	logic [7:0]  release_q, release_d;
	logic [15:0] hold_q, hold_d;
	logic [15:0] win_q, win_d;

	logic [7:0]  pinc, rinc;
	logic [15:0] hinc;
	logic [16:0] winc;

	assign pinc = (press_q == 8'hFF) ? press_q : press_q + 8'd1;
	assign rinc = (release_q == 8'hFF) ? release_q : release_q + 8'd1;
	assign hinc = (hold_q == 16'hFFFF) ? hold_q : hold_q + 16'd1;
	assign winc = {1'b0, win_q} + 17'd1;

	always_comb begin
		phase_d   = phase_q;
		press_d   = press_q;
		release_d = release_q;
		hold_d    = hold_q;
		win_d     = win_q;
		ev.req    = 1'b0;
		ev.kind   = EV_PRESSED;
		if (en) begin
			case (phase_q)
				PH_IDLE: begin
					if (pressed) begin
						press_d = pinc;
						if (pinc >= cfg.debounce) begin
							press_d   = '0;
							hold_d    = '0;
							release_d = '0;
							ev.req    = 1'b1;
							ev.kind   = EV_PRESSED;
							phase_d   = PH_PRESSED;
						end
					end else begin
						press_d = '0;
					end
				end
				PH_PRESSED, PH_LONG: begin
					if (pressed) begin
						release_d = '0;
						if (phase_q == PH_PRESSED) begin
							hold_d = hinc;
							if (cfg.long_ticks != 16'd0 && hinc >= cfg.long_ticks) begin
								ev.req  = 1'b1;
								ev.kind = EV_LONG;
								phase_d = PH_LONG;
							end
						end
					end else begin
						release_d = rinc;
						if (rinc >= cfg.debounce) begin
							ev.req    = 1'b1;
							ev.kind   = EV_RELEASED;
							release_d = '0;
							press_d   = '0;
							if (dc_en) begin
								win_d   = '0;
								phase_d = PH_WAIT;
							end else begin
								phase_d = PH_IDLE;
							end
						end
					end
				end
				PH_WAIT: begin
					// window closes once the count would pass the limit
					if (winc > {1'b0, cfg.dc_ticks}) begin
						press_d = '0;
						phase_d = PH_IDLE;
					end else begin
						win_d = winc[15:0];
						if (pressed) begin
							press_d = pinc;
							if (pinc >= cfg.debounce) begin
								ev.req  = 1'b1;
								ev.kind = EV_DOUBLE;
								press_d = '0;
								phase_d = PH_IDLE;
							end
						end else begin
							press_d = '0;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	assign held_nxt = (phase_d == PH_PRESSED) || (phase_d == PH_LONG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			press_q   <= '0;
			release_q <= '0;
			hold_q    <= '0;
			win_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			press_q   <= press_d;
			release_q <= release_d;
			hold_q    <= hold_d;
			win_q     <= win_d;
		end
	end

endmodule

// ===== hw/rtl/bed_evq.sv =====
// ----------------------------------------------------------------------------
// bed_evq
// Banked event ring queue: up to one push per button per tick, one pop per poll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bed_evq
	import bed_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_en,
	input  ev_req_t            reqs [BUTTONS],
	input  logic [31:0]        stamp,
	input  logic               pop_en,
	output logic               pop_ok,
	output logic [LEVEL_W-1:0] level_nxt,
	output logic [2:0]         dropped,
	output ev_entry_t          rd_entry
);

	localparam int SUM_W = LEVEL_W + 1;

	logic [QPTR_W-1:0]    wp_q, rp_q;
	logic [LEVEL_W-1:0]   fill_q;
	logic [BUTTONS-1:0]   acc;
	logic [QPTR_W-1:0]    idx [BUTTONS];
	logic [REQ_CNT_W-1:0] n_req, n_acc;

	logic               we    [BANKS];
	logic [ROW_W-1:0]   wrow  [BANKS];
	ev_entry_t          wdata [BANKS];
	ev_entry_t          rd_bank [BANKS];
	logic [BANK_W-1:0]  sel_q;

	// requests take consecutive slots in button order until the queue fills
	always_comb begin
		n_req = '0;
		n_acc = '0;
		for (int b = 0; b < BUTTONS; b++) begin
			acc[b] = push_en && reqs[b].req &&
				((SUM_W'(fill_q) + SUM_W'(n_req)) < SUM_W'(QUEUE_DEPTH));
			idx[b] = wp_q + QPTR_W'(n_req);
			n_req  = n_req + REQ_CNT_W'(push_en && reqs[b].req);
			n_acc  = n_acc + REQ_CNT_W'(acc[b]);
		end
	end

	always_comb begin
		for (int j = 0; j < BANKS; j++) begin
			we[j]    = 1'b0;
			wrow[j]  = '0;
			wdata[j] = '0;
			for (int b = 0; b < BUTTONS; b++) begin
				if (acc[b] && idx[b][BANK_W-1:0] == BANK_W'(j)) begin
					we[j]    = 1'b1;
					wrow[j]  = idx[b][QPTR_W-1:BANK_W];
					wdata[j] = {2'(b), reqs[b].kind, stamp};
				end
			end
		end
	end

	assign pop_ok  = pop_en && (fill_q != '0);
	assign dropped = 3'(n_req - n_acc);

	always_comb begin
		if (push_en) begin
			level_nxt = fill_q + LEVEL_W'(n_acc);
		end else if (pop_ok) begin
			level_nxt = fill_q - LEVEL_W'(1);
		end else begin
			level_nxt = fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			fill_q <= level_nxt;
			if (push_en) begin
				wp_q <= wp_q + QPTR_W'(n_acc);
			end
			if (pop_ok) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
		end
	end

	for (genvar j = 0; j < BANKS; j++) begin : g_bank
		ev_entry_t mem [ROWS];

		always_ff @(posedge clk) begin
			if (we[j]) begin
				mem[wrow[j]] <= wdata[j];
			end
			rd_bank[j] <= mem[rp_q[QPTR_W-1:BANK_W]];
		end
	end

	always_ff @(posedge clk) begin
		sel_q <= rp_q[BANK_W-1:0];
	end

	assign rd_entry = rd_bank[sel_q];

endmodule

// ===== hw/rtl/bed_outq.sv =====
// ----------------------------------------------------------------------------
// bed_outq
// Small result buffer between the pipeline and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bed_outq
	import bed_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  result_t               din,
	input  logic                  stall,
	output logic                  valid,
	output result_t               dout,
	output logic [OUTQ_CNT_W-1:0] count
);

	result_t                slot_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wp_q, rp_q;
	logic [OUTQ_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign valid = (cnt_q != '0);
	assign pop   = valid && !stall;
	assign dout  = slot_q[rp_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + OUTQ_PTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + OUTQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
		end
	end

endmodule

// ===== hw/rtl/button_event_debouncer_top.sv =====
// ----------------------------------------------------------------------------
// button_event_debouncer_top
// Path: an item is registered in stage one, then written to the output buffer.
// Throughput: one item per cycle while in_stall is low; the event store is one
// bank per button, so a tick writes every pending event in its own cycle.
// Reset: registers to defaults, buttons idle, queue empty, store not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_event_debouncer_top
	import bed_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [BUTTONS-1:0]    raw_levels,
	input  logic [31:0]           now_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  event_valid,
	output logic [1:0]            event_button,
	output logic [1:0]            event_kind,
	output logic [31:0]           event_stamp,
	output logic [BUTTONS-1:0]    held_mask,
	output logic [LEVEL_W-1:0]    queue_level,
	output logic [2:0]            dropped_now
);

	logic [7:0]         debounce_q;
	logic [15:0]        long_ticks_q;
	logic [15:0]        dc_ticks_q;
	logic [BUTTONS-1:0] active_low_q;
	logic [BUTTONS-1:0] dc_mask_q;
	logic [2:0]         button_count_q;

	lane_cfg_t          lane_cfg;
	logic               accept, tick, poll;
	logic [BUTTONS-1:0] active, held_nxt;
	ev_req_t            reqs [BUTTONS];

	logic               pop_ok;
	logic [LEVEL_W-1:0] level_nxt;
	logic [2:0]         dropped;
	ev_entry_t          rd_entry;

	logic               s1_valid_q;
	logic               pop_ok_s1;
	logic [BUTTONS-1:0] held_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [2:0]         dropped_s1;
	result_t            res_s1, res_out;

	logic [OUTQ_CNT_W-1:0] oq_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= RST_DEBOUNCE;
			long_ticks_q   <= RST_LONG_TICKS;
			dc_ticks_q     <= RST_DC_TICKS;
			active_low_q   <= RST_ACTIVE_LOW;
			dc_mask_q      <= RST_DC_MASK;
			button_count_q <= RST_BUTTON_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:     debounce_q     <= cfg_data[7:0];
				REG_LONG_TICKS:   long_ticks_q   <= cfg_data[15:0];
				REG_DC_TICKS:     dc_ticks_q     <= cfg_data[15:0];
				REG_ACTIVE_LOW:   active_low_q   <= cfg_data[BUTTONS-1:0];
				REG_DC_MASK:      dc_mask_q      <= cfg_data[BUTTONS-1:0];
				REG_BUTTON_COUNT: button_count_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// room for every item in flight, s1 always drains into the buffer
	assign in_stall = ((OUTQ_CNT_W'(s1_valid_q) + oq_count) >= OUTQ_CNT_W'(OUTQ_DEPTH));
	assign accept   = in_valid && !in_stall;
	assign tick     = accept && (cmd == CMD_TICK);
	assign poll     = accept && (cmd == CMD_POLL);

	assign lane_cfg.debounce   = debounce_q;
	assign lane_cfg.long_ticks = long_ticks_q;
	assign lane_cfg.dc_ticks   = dc_ticks_q;

	for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
		// counts above the button total saturate by themselves here
		assign active[b] = (button_count_q > 3'(b));

		bed_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (tick && active[b]),
			.pressed  (raw_levels[b] ^ active_low_q[b]),
			.cfg      (lane_cfg),
			.dc_en    (dc_mask_q[b]),
			.ev       (reqs[b]),
			.held_nxt (held_nxt[b])
		);
	end

	bed_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (tick),
		.reqs      (reqs),
		.stamp     (now_ms),
		.pop_en    (poll),
		.pop_ok    (pop_ok),
		.level_nxt (level_nxt),
		.dropped   (dropped),
		.rd_entry  (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		pop_ok_s1  <= pop_ok;
		held_s1    <= held_nxt & active;
		level_s1   <= level_nxt;
		dropped_s1 <= dropped;
	end

	// event memory read data lines up with stage one
	always_comb begin
		res_s1.event_valid  = pop_ok_s1;
		res_s1.event_button = pop_ok_s1 ? rd_entry.button : 2'd0;
		res_s1.event_kind   = pop_ok_s1 ? rd_entry.kind : EV_PRESSED;
		res_s1.event_stamp  = pop_ok_s1 ? rd_entry.stamp : 32'd0;
		res_s1.held_mask    = held_s1;
		res_s1.queue_level  = level_s1;
		res_s1.dropped_now  = dropped_s1;
	end

	bed_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (s1_valid_q),
		.din    (res_s1),
		.stall  (out_stall),
		.valid  (out_valid),
		.dout   (res_out),
		.count  (oq_count)
	);

	assign event_valid  = res_out.event_valid;
	assign event_button = res_out.event_button;
	assign event_kind   = res_out.event_kind;
	assign event_stamp  = res_out.event_stamp;
	assign held_mask    = res_out.held_mask;
	assign queue_level  = res_out.queue_level;
	assign dropped_now  = res_out.dropped_now;

endmodule
